### hdl/gpb_pkg.sv
package gpb_pkg;

  localparam int RING_DEPTH = 512;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SEQ_W      = 32;
  localparam int TS_W       = 48;
  localparam int SID_W      = 8;
  localparam int PRE_W      = 8;
  localparam int OUT_CNT_W  = 10;
  localparam int SPAN_W     = 18;
  localparam int MS_PER_S   = 1000;
  localparam int GUARD_S    = 3;
  localparam logic [PRE_W-1:0] PRE_RESET = 8'd5;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_END   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  ts;
    logic             key;
  } entry_t;

endpackage

### hdl/gop_prerecord_buffer.sv
// pre-record ring of video frame descriptors (sequence, ms timestamp, key flag) for one
// stream, held oldest first in a single synchronous ram of gpb_pkg::RING_DEPTH entries.
// one beat is taken at a time: in_stall is low only when the block is idle. an action with
// no ring walk goes from acceptance to ST_FINISH, which loads the output register once it
// is free; a key frame whose timestamp has not been aged yet, and a start query, walk the
// ring first, visiting each entry with an address step, then a check of the registered ram
// data. the walk stops at the first key frame that ends the search. the output register
// holds a result while the next beat is accepted. the ram needs no clearing after reset; only
// written entries are ever read. cfg_ready is always high and pre_record_seconds resets to 5.
module gop_prerecord_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_sequence_req,
  input  logic [47:0] in_timestamp_ms,
  input  logic        in_is_key_frame,
  input  logic [7:0]  in_stream_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_stored,
  output logic        out_waiting_key,
  output logic        out_overflow,
  output logic        out_start_found,
  output logic [31:0] out_start_sequence,
  output logic [47:0] out_start_timestamp_ms,
  output logic [9:0]  out_frames_held,
  output logic [9:0]  out_frames_removed,
  output logic [47:0] out_gop_time_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int AW = gpb_pkg::ADDR_W;
  localparam int CW = gpb_pkg::CNT_W;
  localparam int TW = gpb_pkg::TS_W;
  localparam int SW = gpb_pkg::SPAN_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(gpb_pkg::RING_DEPTH);

  // ring slot of entry k counted from the head
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(k);
    if (s >= (CW+1)'(gpb_pkg::RING_DEPTH)) s = s - (CW+1)'(gpb_pkg::RING_DEPTH);
    return s[AW-1:0];
  endfunction

  gpb_pkg::state_t state_r, state_nxt;

  // descriptor ram
  gpb_pkg::entry_t mem [gpb_pkg::RING_DEPTH];
  gpb_pkg::entry_t rd_q, wdata;
  logic            we;
  logic [AW-1:0]   waddr, raddr;

  // ring and stream state
  logic [AW-1:0]                head_r, head_nxt;
  logic [CW-1:0]                held_r, held_nxt;
  logic [gpb_pkg::SEQ_W-1:0]    last_seq_r, last_seq_nxt;
  logic [gpb_pkg::SID_W-1:0]    cur_stream_r, cur_stream_nxt;
  logic                         stream_ok_r, stream_ok_nxt;
  logic [TW-1:0]                last_key_r, last_key_nxt;
  logic [TW-1:0]                last_aged_r, last_aged_nxt;
  logic                         wait_r, wait_nxt;
  logic [TW-1:0]                gop_r, gop_nxt;
  logic [gpb_pkg::PRE_W-1:0]    pre_r;

  // walk control
  logic                         query_r, query_nxt;
  logic [CW-1:0]                k_r, k_nxt;
  logic [TW-1:0]                scan_t_r, scan_t_nxt;
  logic [SW-1:0]                span_r, span_nxt;

  // per-beat result fields
  logic                         stored_r, stored_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         found_r, found_nxt;
  logic [gpb_pkg::SEQ_W-1:0]    fseq_r, fseq_nxt;
  logic [TW-1:0]                fts_r, fts_nxt;
  logic [CW-1:0]                removed_r, removed_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic                         load_out;

  logic                         fresh, gap, accept, cond;
  logic [CW-1:0]                held_eff;
  logic [AW-1:0]                head_eff;

  assign in_stall  = (state_r != gpb_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // key frame still within the window of the walk's reference time
  assign cond = ({1'b0, rd_q.ts} + (TW+1)'(span_r)) > {1'b0, scan_t_r};

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    held_nxt       = held_r;
    last_seq_nxt   = last_seq_r;
    cur_stream_nxt = cur_stream_r;
    stream_ok_nxt  = stream_ok_r;
    last_key_nxt   = last_key_r;
    last_aged_nxt  = last_aged_r;
    wait_nxt       = wait_r;
    gop_nxt        = gop_r;
    query_nxt      = query_r;
    k_nxt          = k_r;
    scan_t_nxt     = scan_t_r;
    span_nxt       = span_r;
    stored_nxt     = stored_r;
    ovf_nxt        = ovf_r;
    found_nxt      = found_r;
    fseq_nxt       = fseq_r;
    fts_nxt        = fts_r;
    removed_nxt    = removed_r;
    out_valid_nxt  = out_valid_r && out_stall;
    load_out       = 1'b0;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '{seq: in_sequence_req, ts: in_timestamp_ms, key: in_is_key_frame};
    raddr          = slot(head_r, k_r);
    fresh          = !stream_ok_r || (cur_stream_r != in_stream_id);
    gap            = !fresh && ((last_seq_r + 32'd1) != in_sequence_req);
    held_eff       = fresh ? '0 : held_r;
    head_eff       = fresh ? '0 : head_r;

    case (state_r)
      gpb_pkg::ST_IDLE: begin
        if (accept) begin
          stored_nxt  = 1'b0;
          ovf_nxt     = 1'b0;
          found_nxt   = 1'b0;
          fseq_nxt    = '0;
          fts_nxt     = '0;
          removed_nxt = '0;
          k_nxt       = '0;
          state_nxt   = gpb_pkg::ST_FINISH;
          case (gpb_pkg::action_t'(in_action))
            gpb_pkg::ACT_FRAME: begin
              if (fresh) begin
                cur_stream_nxt = in_stream_id;
                stream_ok_nxt  = 1'b1;
                head_nxt       = '0;
                held_nxt       = '0;
              end
              if (gap && !in_is_key_frame) begin
                wait_nxt = 1'b1;
              end else if (held_eff >= DEPTH_C) begin
                ovf_nxt = 1'b1;
              end else begin
                we           = 1'b1;
                waddr        = slot(head_eff, held_eff);
                held_nxt     = held_eff + CW'(1);
                stored_nxt   = 1'b1;
                last_seq_nxt = in_sequence_req;
                query_nxt    = 1'b0;
                span_nxt     = (SW'(pre_r) + SW'(gpb_pkg::GUARD_S)) * SW'(gpb_pkg::MS_PER_S);
                if (in_is_key_frame) begin
                  gop_nxt      = in_timestamp_ms - last_key_r;
                  last_key_nxt = in_timestamp_ms;
                  // a key after a gap ages with its own time, otherwise with the previous key
                  scan_t_nxt   = gap ? in_timestamp_ms : last_key_r;
                  if (gap) wait_nxt = 1'b0;
                  if (scan_t_nxt != last_aged_r) begin
                    last_aged_nxt = scan_t_nxt;
                    state_nxt     = gpb_pkg::ST_SCAN_RD;
                  end
                end
              end
            end
            gpb_pkg::ACT_QUERY: begin
              if (!fresh) begin
                query_nxt  = 1'b1;
                scan_t_nxt = in_timestamp_ms;
                span_nxt   = SW'(pre_r) * SW'(gpb_pkg::MS_PER_S);
                state_nxt  = gpb_pkg::ST_SCAN_RD;
              end
            end
            gpb_pkg::ACT_END: begin
              head_nxt = '0;
              held_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      gpb_pkg::ST_SCAN_RD: begin
        // ram address goes out here, data is checked next cycle
        state_nxt = (k_r == held_r) ? gpb_pkg::ST_FINISH : gpb_pkg::ST_SCAN_CHK;
      end
      gpb_pkg::ST_SCAN_CHK: begin
        state_nxt = gpb_pkg::ST_SCAN_RD;
        k_nxt     = k_r + CW'(1);
        if (rd_q.key) begin
          if (cond) begin
            state_nxt = gpb_pkg::ST_FINISH;
            if (query_r) begin
              if (!found_r) begin
                found_nxt = 1'b1;
                fseq_nxt  = rd_q.seq;
                fts_nxt   = rd_q.ts;
              end
            end else begin
              // drop everything before this key frame
              head_nxt    = slot(head_r, k_r);
              held_nxt    = held_r - k_r;
              removed_nxt = k_r;
            end
          end else if (query_r) begin
            found_nxt = 1'b1;
            fseq_nxt  = rd_q.seq;
            fts_nxt   = rd_q.ts;
          end
        end
      end
      gpb_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = gpb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gpb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gpb_pkg::ST_IDLE;
      head_r       <= '0;
      held_r       <= '0;
      last_seq_r   <= '1;
      cur_stream_r <= '0;
      stream_ok_r  <= 1'b0;
      last_key_r   <= '0;
      last_aged_r  <= '0;
      wait_r       <= 1'b0;
      gop_r        <= '0;
      pre_r        <= gpb_pkg::PRE_RESET;
      out_valid_r  <= 1'b0;
      k_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      held_r       <= held_nxt;
      last_seq_r   <= last_seq_nxt;
      cur_stream_r <= cur_stream_nxt;
      stream_ok_r  <= stream_ok_nxt;
      last_key_r   <= last_key_nxt;
      last_aged_r  <= last_aged_nxt;
      wait_r       <= wait_nxt;
      gop_r        <= gop_nxt;
      out_valid_r  <= out_valid_nxt;
      k_r          <= k_nxt;
      if (cfg_valid && cfg_ready) pre_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    query_r   <= query_nxt;
    scan_t_r  <= scan_t_nxt;
    span_r    <= span_nxt;
    stored_r  <= stored_nxt;
    ovf_r     <= ovf_nxt;
    found_r   <= found_nxt;
    fseq_r    <= fseq_nxt;
    fts_r     <= fts_nxt;
    removed_r <= removed_nxt;
    if (load_out) begin
      out_frame_stored       <= stored_r;
      out_waiting_key        <= wait_r;
      out_overflow           <= ovf_r;
      out_start_found        <= found_r;
      out_start_sequence     <= fseq_r;
      out_start_timestamp_ms <= fts_r;
      out_frames_held        <= gpb_pkg::OUT_CNT_W'(held_r);
      out_frames_removed     <= gpb_pkg::OUT_CNT_W'(removed_r);
      out_gop_time_ms        <= gop_r;
    end
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n) held_r <= DEPTH_C)
    else $error("ring count beyond depth");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gpb_pkg::ST_SCAN_CHK) |-> (k_r < held_r))
    else $error("walk past end of ring");
  a_store_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_frame_stored && out_overflow))
    else $error("frame both stored and refused");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gpb_pkg::ST_FINISH && out_valid_r && out_stall) |=> (state_r == gpb_pkg::ST_FINISH))
    else $error("result lost while output stalled");
`endif

endmodule
